// ----- sv/ffsa_pkg.sv -----
package ffsa_pkg;

  // Default structure sizes.
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int ADDR_BITS_DEF    = 16;

  // Fixed field widths of the request, result and register.
  localparam int OWNER_W  = 8;
  localparam int SIZE_W   = 17;
  localparam int BSTART_W = 16;
  localparam int BADDR_W  = 16;
  localparam int HEAP_W   = 17;

  localparam logic [HEAP_W-1:0] HEAP_RST = 17'd65536;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_SH_RD,
    S_SH_WR,
    S_SPLIT_LO,
    S_SPLIT_HI,
    S_FNX_RD,
    S_FNX_CHK,
    S_RM_CHK,
    S_RM_RD,
    S_RM_WR,
    S_FPV,
    S_FPV_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                req_type;
    logic [OWNER_W-1:0]  owner_id;
    logic [SIZE_W-1:0]   req_size;
    logic [BSTART_W-1:0] block_start;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BADDR_W-1:0] block_addr;
  } res_t;

  // Handshake between the sequencer and the top level.
  typedef struct packed {
    logic ready;
    logic done;
  } ctl_stat_t;

endpackage

// ----- sv/first_fit_segment_allocator_top.sv -----
// Each scanned table entry is read and then checked; on a split each entry moved up is read and
// then written; on a merge each entry moved down is checked, read and then written. Setup and
// write-back states come before and after these steps.
// One transaction at a time; the registered-read table memory and the shared adder set the
// per-entry cost. A finished result waits in an output register.
// Reset, and a heap_size write seen while idle, write the table as a single free segment.
module first_fit_segment_allocator_top #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,       // heap_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // owner_id[7:0], req_size[24:8], block_start[40:25]
  input  logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // block_addr[15:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  import ffsa_pkg::*;

  localparam int LEN_W = ADDR_BITS + 1;
  localparam int CW    = (LEN_W > HEAP_W) ? LEN_W : HEAP_W;
  localparam logic [CW-1:0] HEAP_LIM = CW'(1) << ADDR_BITS;
  localparam logic [CW-1:0] RST_W    = CW'(HEAP_RST);
  localparam logic [LEN_W-1:0] HEAP_RST_SAT =
    LEN_W'((RST_W > HEAP_LIM) ? HEAP_LIM : RST_W);

  logic [LEN_W-1:0] heap;
  logic [CW-1:0]    cfg_wide;
  req_t             req;
  res_t             res;
  ctl_stat_t        stat;
  logic             load;

  assign cfg_wide = CW'(cfg_data);

  // Heap size register, saturated to the address space.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap <= HEAP_RST_SAT;
    end else if (cfg_we) begin
      heap <= LEN_W'((cfg_wide > HEAP_LIM) ? HEAP_LIM : cfg_wide);
    end
  end

  assign req.req_type    = s_axis_tuser[0];
  assign req.owner_id    = s_axis_tdata[7:0];
  assign req.req_size    = s_axis_tdata[24:8];
  assign req.block_start = s_axis_tdata[40:25];

  assign s_axis_tready = stat.ready;
  assign load          = stat.done && (!m_axis_tvalid || m_axis_tready);

  ffsa_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .init_req (cfg_we),
    .heap     (heap),
    .start    (s_axis_tvalid && s_axis_tready),
    .req_in   (req),
    .done_ack (load),
    .stat     (stat),
    .res      (res)
  );

  // Output register for the result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (load) begin
      m_axis_tdata <= res.block_addr;
      m_axis_tuser <= res.status;
    end
  end

endmodule

// ----- sv/ffsa_ram.sv -----
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ffsa_alu.sv -----
module ffsa_alu #(
  parameter int W = 17
) (
  input  ffsa_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              gt
);

  import ffsa_pkg::*;

  // Shared adder and magnitude compare.
  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
    gt = a > b;
  end

endmodule

// ----- sv/ffsa_ctrl.sv -----
module ffsa_ctrl #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  init_req,
  input  logic [ADDR_BITS:0]    heap,
  input  logic                  start,
  input  ffsa_pkg::req_t        req_in,
  input  logic                  done_ack,
  output ffsa_pkg::ctl_stat_t   stat,
  output ffsa_pkg::res_t        res
);

  import ffsa_pkg::*;

  localparam int LEN_W = ADDR_BITS + 1;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ALU_W = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
    logic [OWNER_W-1:0]   owner;
    logic                 free;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  state_t               state, state_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [IDX_W-1:0]     jdx, jdx_next;
  logic [CNT_W-1:0]     count, count_next;
  ent_t                 cur, cur_next;
  req_t                 req, req_next;
  res_t                 res_next;
  logic [ADDR_BITS-1:0] tmp_start, tmp_start_next;
  logic                 rm_second, rm_second_next;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  ent_t                 wdata;
  logic [IDX_W-1:0]     raddr;
  logic [ENT_W-1:0]     rdata_raw;
  ent_t                 rd;

  alu_op_t              op;
  logic [ALU_W-1:0]     opa, opb, alu_res;
  logic                 alu_gt;

  logic [CNT_W-1:0]     idx_p1;
  logic [CNT_W-1:0]     jdx_p1;

  ffsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  ffsa_alu #(.W(ALU_W)) u_alu (
    .op  (op),
    .a   (opa),
    .b   (opb),
    .res (alu_res),
    .gt  (alu_gt)
  );

  assign rd     = ent_t'(rdata_raw);
  assign idx_p1 = CNT_W'(idx) + CNT_W'(1);
  assign jdx_p1 = CNT_W'(jdx) + CNT_W'(1);

  assign stat.ready = (state == S_IDLE);
  assign stat.done  = (state == S_DONE);

  // Read address for the entry that the next state inspects.
  always_comb begin
    unique case (state)
      S_SH_RD:  raddr = IDX_W'(jdx - IDX_W'(1));
      S_FNX_RD: raddr = IDX_W'(idx + IDX_W'(1));
      S_RM_RD:  raddr = IDX_W'(jdx + IDX_W'(1));
      S_FPV:    raddr = IDX_W'(idx - IDX_W'(1));
      default:  raddr = idx;
    endcase
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= CNT_W'(1);
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx       <= idx_next;
    jdx       <= jdx_next;
    cur       <= cur_next;
    req       <= req_next;
    res       <= res_next;
    tmp_start <= tmp_start_next;
    rm_second <= rm_second_next;
  end

  // Sequencer: table scan, shifts, split and merges.
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    jdx_next       = jdx;
    count_next     = count;
    cur_next       = cur;
    req_next       = req;
    res_next       = res;
    tmp_start_next = tmp_start;
    rm_second_next = rm_second;
    we             = 1'b0;
    waddr          = idx;
    wdata          = cur;
    op             = ALU_ADD;
    opa            = '0;
    opb            = '0;

    unique case (state)
      S_INIT: begin
        we          = 1'b1;
        waddr       = '0;
        wdata.start = '0;
        wdata.len   = heap;
        wdata.owner = '0;
        wdata.free  = 1'b1;
        count_next  = CNT_W'(1);
        state_next  = S_IDLE;
      end

      S_IDLE: begin
        if (init_req) begin
          state_next = S_INIT;
        end else if (start) begin
          req_next            = req_in;
          idx_next            = '0;
          res_next.block_addr = '0;
          if (req_in.req_type == REQ_ALLOC && req_in.req_size == '0) begin
            res_next.status = ST_NOFIT;
            state_next      = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end

      S_RD: begin
        state_next = S_CHK;
      end

      // Test one entry of the scan.
      S_CHK: begin
        opa = ALU_W'(rd.len);
        opb = ALU_W'(req.req_size);
        if (req.req_type == REQ_ALLOC) begin
          if (rd.free && alu_gt) begin
            cur_next = rd;
            if (count == CNT_W'(MAX_SEGMENTS)) begin
              res_next.status = ST_NOTFOUND;
              state_next      = S_DONE;
            end else if (count > idx_p1) begin
              jdx_next   = IDX_W'(count);
              state_next = S_SH_RD;
            end else begin
              state_next = S_SPLIT_LO;
            end
          end else if (idx_p1 == count) begin
            res_next.status = ST_NOFIT;
            state_next      = S_DONE;
          end else begin
            idx_next   = IDX_W'(idx_p1);
            state_next = S_RD;
          end
        end else begin
          if (!rd.free && BSTART_W'(rd.start) == req.block_start
              && rd.owner == req.owner_id) begin
            cur_next       = rd;
            cur_next.free  = 1'b1;
            cur_next.owner = '0;
            rm_second_next = 1'b0;
            state_next     = (idx_p1 < count) ? S_FNX_RD : S_FPV;
          end else if (idx_p1 == count) begin
            res_next.status = ST_NOTFOUND;
            state_next      = S_DONE;
          end else begin
            idx_next   = IDX_W'(idx_p1);
            state_next = S_RD;
          end
        end
      end

      // Open a slot by moving entries up one place.
      S_SH_RD: begin
        state_next = S_SH_WR;
      end

      S_SH_WR: begin
        we       = 1'b1;
        waddr    = jdx;
        wdata    = rd;
        jdx_next = IDX_W'(jdx - IDX_W'(1));
        if (CNT_W'(jdx) > idx_p1 + CNT_W'(1)) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_SPLIT_LO;
        end
      end

      // Allocated part at the low end.
      S_SPLIT_LO: begin
        opa            = ALU_W'(cur.start);
        opb            = ALU_W'(req.req_size);
        tmp_start_next = ADDR_BITS'(alu_res);
        we             = 1'b1;
        waddr          = idx;
        wdata.start    = cur.start;
        wdata.len      = LEN_W'(req.req_size);
        wdata.owner    = req.owner_id;
        wdata.free     = 1'b0;
        state_next     = S_SPLIT_HI;
      end

      // Remaining free part after it.
      S_SPLIT_HI: begin
        op                  = ALU_SUB;
        opa                 = ALU_W'(cur.len);
        opb                 = ALU_W'(req.req_size);
        we                  = 1'b1;
        waddr               = IDX_W'(idx + IDX_W'(1));
        wdata.start         = tmp_start;
        wdata.len           = LEN_W'(alu_res);
        wdata.owner         = cur.owner;
        wdata.free          = 1'b1;
        count_next          = CNT_W'(count + CNT_W'(1));
        res_next.status     = ST_OK;
        res_next.block_addr = BADDR_W'(cur.start);
        state_next          = S_DONE;
      end

      S_FNX_RD: begin
        state_next = S_FNX_CHK;
      end

      // Merge with the following free segment.
      S_FNX_CHK: begin
        opa = ALU_W'(cur.len);
        opb = ALU_W'(rd.len);
        if (rd.free) begin
          cur_next.len = LEN_W'(alu_res);
          jdx_next     = IDX_W'(idx + IDX_W'(1));
          state_next   = S_RM_CHK;
        end else begin
          state_next = S_FPV;
        end
      end

      // Remove entry jdx by moving later entries down.
      S_RM_CHK: begin
        if (jdx_p1 < count) begin
          state_next = S_RM_RD;
        end else begin
          count_next = CNT_W'(count - CNT_W'(1));
          if (rm_second) begin
            res_next.status = ST_OK;
            state_next      = S_DONE;
          end else begin
            state_next = S_FPV;
          end
        end
      end

      S_RM_RD: begin
        state_next = S_RM_WR;
      end

      S_RM_WR: begin
        we         = 1'b1;
        waddr      = jdx;
        wdata      = rd;
        jdx_next   = IDX_W'(jdx_p1);
        state_next = S_RM_CHK;
      end

      // Look at the preceding segment, if there is one.
      S_FPV: begin
        if (idx == '0) begin
          we              = 1'b1;
          waddr           = idx;
          wdata           = cur;
          res_next.status = ST_OK;
          state_next      = S_DONE;
        end else begin
          state_next = S_FPV_CHK;
        end
      end

      S_FPV_CHK: begin
        opa = ALU_W'(rd.len);
        opb = ALU_W'(cur.len);
        we  = 1'b1;
        if (rd.free) begin
          waddr          = IDX_W'(idx - IDX_W'(1));
          wdata          = rd;
          wdata.len      = LEN_W'(alu_res);
          jdx_next       = idx;
          rm_second_next = 1'b1;
          state_next     = S_RM_CHK;
        end else begin
          waddr           = idx;
          wdata           = cur;
          res_next.status = ST_OK;
          state_next      = S_DONE;
        end
      end

      S_DONE: begin
        if (done_ack) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import ffsa_pkg::*;

  localparam int NSEG     = 32;
  localparam int HEAP_MAX = 65536;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    status_t     status;
    logic [15:0] addr;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  first_fit_segment_allocator_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Shadow copy of the segment table.
  int unsigned heap_len;
  int unsigned tbl_start [NSEG];
  int unsigned tbl_len [NSEG];
  int unsigned tbl_owner [NSEG];
  bit          tbl_free [NSEG];
  int unsigned tbl_count;

  req_t          pending_reqs[$];
  alloc_result_t expected_results[$];
  // Blocks handed out so far, used to build matching free requests.
  int unsigned   live_start[$];
  int unsigned   live_owner[$];

  bit          failed = 1'b0;
  bit          quiet_tail = 1'b0;
  int          watchdog = 0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic void table_reset(int unsigned value);
    heap_len = (value > HEAP_MAX) ? HEAP_MAX : value;
    for (int k = 0; k < NSEG; k++) begin
      tbl_start[k] = 0;
      tbl_len[k] = 0;
      tbl_owner[k] = 0;
      tbl_free[k] = 1'b0;
    end
    tbl_len[0] = heap_len;
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic void drop_entry(int unsigned k);
    for (int unsigned j = k; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j + 1];
      tbl_len[j] = tbl_len[j + 1];
      tbl_owner[j] = tbl_owner[j + 1];
      tbl_free[j] = tbl_free[j + 1];
    end
    tbl_count--;
  endfunction

  // Computes the allocator's answer to one request and updates the table.
  function automatic alloc_result_t serve_request(req_t r);
    alloc_result_t res;
    int unsigned i;
    res.status = ST_OK;
    res.addr = '0;
    if (r.req_type == REQ_ALLOC) begin
      if (r.req_size == 0) begin
        res.status = ST_NOFIT;
        return res;
      end
      for (i = 0; i < tbl_count; i++)
        if (tbl_free[i] && tbl_len[i] > r.req_size) break;
      if (i >= tbl_count) begin
        res.status = ST_NOFIT;
        return res;
      end
      if (tbl_count >= NSEG) begin
        res.status = ST_NOTFOUND;
        return res;
      end
      for (int unsigned j = tbl_count; j > i; j--) begin
        tbl_start[j] = tbl_start[j - 1];
        tbl_len[j] = tbl_len[j - 1];
        tbl_owner[j] = tbl_owner[j - 1];
        tbl_free[j] = tbl_free[j - 1];
      end
      tbl_count++;
      tbl_len[i] = r.req_size;
      tbl_owner[i] = r.owner_id;
      tbl_free[i] = 1'b0;
      tbl_start[i + 1] = (tbl_start[i] + r.req_size) & (HEAP_MAX - 1);
      tbl_len[i + 1] -= r.req_size;
      res.addr = tbl_start[i][15:0];
    end else begin
      for (i = 0; i < tbl_count; i++)
        if (!tbl_free[i] && tbl_start[i] == r.block_start && tbl_owner[i] == r.owner_id) break;
      if (i >= tbl_count) begin
        res.status = ST_NOTFOUND;
        return res;
      end
      tbl_free[i] = 1'b1;
      tbl_owner[i] = 0;
      if (i + 1 < tbl_count && tbl_free[i + 1]) begin
        tbl_len[i] += tbl_len[i + 1];
        drop_entry(i + 1);
      end
      if (i > 0 && tbl_free[i - 1]) begin
        tbl_len[i - 1] += tbl_len[i];
        drop_entry(i);
      end
    end
    return res;
  endfunction

  // Queues a request, predicts its result and tracks live blocks.
  task automatic push_req(logic kind, int unsigned owner, int unsigned size,
                          int unsigned start);
    req_t r;
    alloc_result_t res;
    r.req_type = kind;
    r.owner_id = owner[7:0];
    r.req_size = size[16:0];
    r.block_start = start[15:0];
    res = serve_request(r);
    if (kind == REQ_ALLOC && res.status == ST_OK) begin
      live_start.push_back(res.addr);
      live_owner.push_back(r.owner_id);
    end
    pending_reqs.push_back(r);
    expected_results.push_back(res);
  endtask

  task automatic free_live(int idx);
    push_req(REQ_FREE, live_owner[idx], $urandom, live_start[idx]);
    live_start.delete(idx);
    live_owner.delete(idx);
  endtask

  task automatic drain_and_config(int unsigned value);
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (2 * NSEG + 10) @(posedge clk);
    cfg_data <= value[16:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_reset(value);
    live_start.delete();
    live_owner.delete();
    repeat (2) @(posedge clk);
  endtask

  // Random phase: mostly allocations and matched frees, some noise.
  task automatic random_phase(int n, int unsigned max_size);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        push_req(REQ_ALLOC, $urandom_range(0, 255), $urandom_range(1, max_size),
                 $urandom);
      else if (sel < 85 && live_start.size() != 0)
        free_live($urandom_range(0, live_start.size() - 1));
      else if (sel < 92)
        push_req(REQ_FREE, $urandom_range(0, 255), $urandom, $urandom_range(0, 65535));
      else
        push_req(REQ_ALLOC, $urandom_range(0, 255), $urandom_range(0, 131071), $urandom);
    end
  endtask

  // Stimulus and register writes.
  initial begin
    table_reset(HEAP_MAX);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Directed: extremes, exact fit, zero request, oversized, bad frees.
    push_req(REQ_ALLOC, 0, 0, 0);
    push_req(REQ_ALLOC, 255, 65536, 65535);
    push_req(REQ_ALLOC, 255, 131071, 0);
    push_req(REQ_ALLOC, 1, 1, 0);
    push_req(REQ_ALLOC, 2, 65534, 0);
    push_req(REQ_FREE, 1, 0, 0);
    push_req(REQ_FREE, 1, 0, 0);
    push_req(REQ_FREE, 3, 0, 1);
    push_req(REQ_FREE, 2, 131071, 1);
    push_req(REQ_FREE, 255, 0, 65535);
    live_start.delete();
    live_owner.delete();

    // Small heap: table fills up, exact fit refused.
    drain_and_config(40);
    for (int k = 0; k < 34; k++) push_req(REQ_ALLOC, k, 1, 0);
    push_req(REQ_ALLOC, 9, 40, 0);
    random_phase(60, 3);

    // Zero heap and oversized heap values.
    drain_and_config(0);
    push_req(REQ_ALLOC, 5, 1, 0);
    drain_and_config(131071);
    random_phase(80, 8000);
    drain_and_config(1);
    push_req(REQ_ALLOC, 4, 1, 0);
    drain_and_config(300);
    random_phase(150, 40);
    drain_and_config(65536);
    random_phase(100, 5000);
    quiet_tail = 1'b1;
    random_phase(60, 2000);
  end

  // Driver: presents the oldest pending request.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) pending_reqs.pop_front();
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if ((!s_axis_tvalid || s_axis_tready) && !quiet_tail &&
                   $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 14);
        s_axis_tvalid <= 1'b0;
      end else begin
        int depth;
        depth = pending_reqs.size();
        if (depth > 0) begin
          req_t r;
          r = pending_reqs[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= r.req_type;
          s_axis_tdata <= {7'd0, r.block_start, r.req_size, r.owner_id};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and applies backpressure.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d addr=%0d", $time,
                   m_axis_tuser, m_axis_tdata);
          failed = 1'b1;
        end else begin
          alloc_result_t e;
          e = expected_results.pop_front();
          if (m_axis_tuser !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, m_axis_tuser);
            failed = 1'b1;
          end
          if (m_axis_tdata !== e.addr) begin
            $display("%0t: block_addr expected %0d actual %0d", $time, e.addr,
                     m_axis_tdata);
            failed = 1'b1;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End of run and stall watchdog.
  initial begin
    @(negedge rst);
    wait (quiet_tail);
    while (pending_reqs.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        watchdog = 0;
      else
        watchdog++;
      if (watchdog >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
    repeat (2 * NSEG + 10) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for the phases before the tail.
  initial begin : early_watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (!quiet_tail) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we ||
          (pending_reqs.size() == 0 && expected_results.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
